/* rtl/pba_pkg.sv */
// Shared types and constants of the priority behaviour arbiter.
`timescale 1ns / 1ps

package pba_pkg;

    localparam int ID_W   = 4;
    localparam int PRIO_W = 16;
    localparam int MASK_W = 16;
    localparam int FUNC_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNREGISTER = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RUN        = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_SWEEP      = 3'd4;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic              rflag;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ID_W-1:0]   key_id;
        logic [PRIO_W-1:0] prio;
        logic              rflag;
        logic [MASK_W-1:0] mask;
    } cmd_t;

    localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, id: '0, prio: '0, rflag: 1'b0};

endpackage

/* rtl/pba_first.sv */
// Picks the lowest set bit of a request vector as a one-hot grant.
`timescale 1ns / 1ps

module pba_first #(
    parameter int N = 16
) (
    input  logic [N-1:0] req,
    output logic [N-1:0] grant
);

    for (genvar i = 0; i < N; i++) begin : g_bit
        localparam logic [N-1:0] LOWER = (N'(1) << i) - N'(1);
        assign grant[i] = req[i] & ~(|(req & LOWER));
    end

endmodule

/* rtl/pba_cell.sv */
// One slot of the sorted behaviour table, shifting entries to and from its neighbours.
`timescale 1ns / 1ps

module pba_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  pba_pkg::cmd_t  cmd,
    input  pba_pkg::entry_t left_entry,
    input  logic           left_stay,
    input  pba_pkg::entry_t right_entry,
    input  logic           pull_right,
    output pba_pkg::entry_t entry,
    output logic           stay,
    output logic           match,
    output logic           act
);

    import pba_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic              rflag_reg;
    logic              rflag_next;

    assign stay  = valid_reg && (prio_reg >= cmd.prio);
    assign match = valid_reg && (id_reg == cmd.key_id);
    assign act   = valid_reg && cmd.mask[id_reg];
    assign entry = '{valid: valid_reg, id: id_reg, prio: prio_reg, rflag: rflag_reg};

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        rflag_next = rflag_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_INSERT:
            begin
                if (!stay) begin
                    if (left_stay) begin
                        valid_next = 1'b1;
                        id_next    = cmd.key_id;
                        prio_next  = cmd.prio;
                        rflag_next = cmd.rflag;
                    end else begin
                        valid_next = left_entry.valid;
                        id_next    = left_entry.id;
                        prio_next  = left_entry.prio;
                        rflag_next = left_entry.rflag;
                    end
                end
            end
            OP_DELETE:
            begin
                if (pull_right) begin
                    valid_next = right_entry.valid;
                    id_next    = right_entry.id;
                    prio_next  = right_entry.prio;
                    rflag_next = right_entry.rflag;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        rflag_reg <= rflag_next;
    end

endmodule

/* rtl/priority_behaviour_arbiter.sv */
// Top level of the priority behaviour arbiter: command decode, cell row and result register.
//
//   Channel   Handshake       Payload
//   command   start / busy    func, behavior_id, priority_req, has_reset, act_mask
//   result    done (strobe)   chosen_id, ok, last
//
// Clear, register, unregister and run each give a single result: the cell row is updated on
// the accepting edge and the result appears on the next cycle, with busy low.
// A reset sweep holds busy while it emits one result per cycle, one for each flagged entry,
// from its pending vector; with no flagged entry it gives a single result like the others.
// Reset clears every slot's valid bit and the sweep state. The receiver cannot stall, so
// each result is a transaction completed in the cycle it is shown.
`timescale 1ns / 1ps

module priority_behaviour_arbiter #(
    parameter int NUM_SLOTS = 16,
    parameter int NUM_IDS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [pba_pkg::FUNC_W-1:0] func,
    input  logic [pba_pkg::ID_W-1:0]   behavior_id,
    input  logic [pba_pkg::PRIO_W-1:0] priority_req,
    input  logic                       has_reset,
    input  logic [pba_pkg::MASK_W-1:0] act_mask,
    output logic                       done,
    output logic [pba_pkg::ID_W-1:0]   chosen_id,
    output logic                       ok,
    output logic                       last
);

    import pba_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    cmd_t                 cmd;
    entry_t               cell_entry [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] stay_vec;
    logic [NUM_SLOTS-1:0] match_vec;
    logic [NUM_SLOTS-1:0] act_vec;
    logic [NUM_SLOTS-1:0] valid_vec;
    logic [NUM_SLOTS-1:0] flag_vec;
    logic [NUM_SLOTS-1:0] gone_vec;
    logic [NUM_SLOTS-1:0] run_grant;
    logic [NUM_SLOTS-1:0] sweep_grant;
    logic [ID_W-1:0]      run_id;
    logic [ID_W-1:0]      sweep_id;

    logic                 state_reg;
    logic                 state_next;
    logic [NUM_SLOTS-1:0] pend_reg;
    logic [NUM_SLOTS-1:0] pend_next;
    logic                 done_reg;
    logic                 done_next;
    logic [ID_W-1:0]      chosen_reg;
    logic [ID_W-1:0]      chosen_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic                 last_reg;
    logic                 last_next;

    logic                 accept;
    logic                 reg_ok;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        localparam logic [NUM_SLOTS-1:0] UPTO = (NUM_SLOTS'(1) << (i + 1)) - NUM_SLOTS'(1);

        entry_t left_entry;
        entry_t right_entry;
        logic   left_stay;

        if (i == 0) begin : g_head
            assign left_entry = ENTRY_EMPTY;
            assign left_stay  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_stay  = stay_vec[i-1];
        end

        if (i == NUM_SLOTS - 1) begin : g_tail
            assign right_entry = ENTRY_EMPTY;
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        assign gone_vec[i]  = |(match_vec & UPTO);
        assign valid_vec[i] = cell_entry[i].valid;
        assign flag_vec[i]  = cell_entry[i].valid & cell_entry[i].rflag;

        pba_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_stay   (left_stay),
            .right_entry (right_entry),
            .pull_right  (gone_vec[i]),
            .entry       (cell_entry[i]),
            .stay        (stay_vec[i]),
            .match       (match_vec[i]),
            .act         (act_vec[i])
        );
    end

    pba_first #(.N(NUM_SLOTS)) u_run_pick (
        .req   (act_vec),
        .grant (run_grant)
    );

    pba_first #(.N(NUM_SLOTS)) u_sweep_pick (
        .req   (pend_reg),
        .grant (sweep_grant)
    );

    always_comb
    begin
        run_id   = '0;
        sweep_id = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (run_grant[i]) begin
                run_id = run_id | cell_entry[i].id;
            end
            if (sweep_grant[i]) begin
                sweep_id = sweep_id | cell_entry[i].id;
            end
        end
    end

    assign busy   = (state_reg == ST_SWEEP);
    assign accept = start && !busy;
    assign reg_ok = (int'(behavior_id) < NUM_IDS) && !valid_vec[NUM_SLOTS-1] && !(|match_vec);

    always_comb
    begin
        cmd.op      = OP_HOLD;
        cmd.key_id  = behavior_id;
        cmd.prio    = priority_req;
        cmd.rflag   = has_reset;
        cmd.mask    = act_mask;
        state_next  = state_reg;
        pend_next   = pend_reg;
        done_next   = 1'b0;
        chosen_next = '0;
        ok_next     = 1'b0;
        last_next   = 1'b1;
        if (state_reg == ST_SWEEP) begin
            done_next   = 1'b1;
            chosen_next = sweep_id;
            ok_next     = 1'b1;
            pend_next   = pend_reg & ~sweep_grant;
            last_next   = (pend_next == '0);
            if (last_next) begin
                state_next = ST_IDLE;
            end
        end else if (accept) begin
            done_next = 1'b1;
            case (func)
                FUNC_CLEAR:
                begin
                    cmd.op  = OP_CLEAR;
                    ok_next = 1'b1;
                end
                FUNC_REGISTER:
                begin
                    cmd.op  = reg_ok ? OP_INSERT : OP_HOLD;
                    ok_next = reg_ok;
                end
                FUNC_UNREGISTER:
                begin
                    cmd.op  = (|match_vec) ? OP_DELETE : OP_HOLD;
                    ok_next = |match_vec;
                end
                FUNC_RUN:
                begin
                    chosen_next = run_id;
                    ok_next     = |act_vec;
                end
                FUNC_SWEEP:
                begin
                    if (|flag_vec) begin
                        done_next  = 1'b0;
                        pend_next  = flag_vec;
                        state_next = ST_SWEEP;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chosen_reg <= chosen_next;
        ok_reg     <= ok_next;
        last_reg   <= last_next;
    end

    assign done      = done_reg;
    assign chosen_id = chosen_reg;
    assign ok        = ok_reg;
    assign last      = last_reg;

    // The table stays packed: valid slots always form an unbroken run from slot zero.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + NUM_SLOTS'(1))) == '0)
        else $error("behaviour table is not packed");

    // A sweep in progress always has at least one flagged entry still to report.
    a_sweep_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (pend_reg != '0))
        else $error("sweep running with nothing pending");

    // The final result of a transaction leaves the block free for the next command.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |-> !busy)
        else $error("busy still high after the final result");

    // A run gives its result on the next cycle, and a failed run reports identifier zero.
    a_run_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_RUN)) |=> (done && last && (ok || (chosen_id == '0))))
        else $error("run result missing or malformed");

endmodule
